[design/bba_pkg.sv]
package bba_pkg;

  localparam int unsigned MAX_BLOCKS = 1024;  // capacity of the used-block map
  localparam int unsigned ADDR_W  = 48;  // address fields and base register
  localparam int unsigned REQ_W   = 20;  // request size and block size
  localparam int unsigned CNT_W   = 11;  // block count register
  localparam int unsigned IDX_W   = 11;  // block index and search position
  localparam int unsigned BIT_W   = 5;   // bit position inside a map word
  localparam int unsigned WI_W    = IDX_W - BIT_W;  // map word number
  localparam int unsigned WORD_W  = 32;  // bits in one map word
  localparam int unsigned REM_W   = REQ_W + IDX_W;  // divider remainder
  localparam int unsigned STEP_W  = 4;   // holds IDX_W - 1
  localparam int unsigned CFG_W   = 2;   // configuration index

  localparam logic [CFG_W-1:0] CFG_BASE  = 2'd0;
  localparam logic [CFG_W-1:0] CFG_BYTES = 2'd1;
  localparam logic [CFG_W-1:0] CFG_COUNT = 2'd2;

  localparam logic MODE_ALLOC = 1'b0;

  localparam logic [ADDR_W-1:0] RST_BASE  = 48'd0;
  localparam logic [REQ_W-1:0]  RST_BYTES = 20'd4096;
  localparam logic [CNT_W-1:0]  RST_COUNT = 11'd1024;

  typedef enum logic [1:0] {
    ST_OK       = 2'd0,
    ST_OVERSIZE = 2'd1,
    ST_FULL     = 2'd2,
    ST_BADADDR  = 2'd3
  } status_e;

  typedef struct packed {
    logic              start;
    logic [ADDR_W-1:0] dividend;
    logic [REQ_W-1:0]  divisor;
  } div_req_t;

  typedef struct packed {
    logic             done;
    logic             overflow;  // quotient does not fit in IDX_W bits
    logic [IDX_W-1:0] quotient;
  } div_rsp_t;

endpackage

[design/bba_div.sv]
module bba_div (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  bba_pkg::div_req_t  req_i,
  output bba_pkg::div_rsp_t  rsp_o
);

  logic                               busy_q, busy_d;
  logic                               done_q, done_d;
  logic                               ovf_q, ovf_d;
  logic [bba_pkg::STEP_W-1:0]         step_q, step_d;
  logic [bba_pkg::REM_W-1:0]          rem_q, rem_d;
  logic [bba_pkg::REM_W-1:0]          dv_q, dv_d;
  logic [bba_pkg::IDX_W-1:0]          quo_q, quo_d;
  logic                               fits;

  assign fits = (rem_q >= dv_q);

  always_comb begin
    busy_d = busy_q;
    done_d = 1'b0;
    ovf_d  = ovf_q;
    step_d = step_q;
    rem_d  = rem_q;
    dv_d   = dv_q;
    quo_d  = quo_q;
    if (req_i.start) begin
      // A quotient of 2^IDX_W or more can never name a block.
      ovf_d = (req_i.dividend >=
               bba_pkg::ADDR_W'({req_i.divisor, {bba_pkg::IDX_W{1'b0}}}));
      if (ovf_d) begin
        done_d = 1'b1;
      end else begin
        busy_d = 1'b1;
        rem_d  = req_i.dividend[bba_pkg::REM_W-1:0];
        dv_d   = bba_pkg::REM_W'(req_i.divisor) << (bba_pkg::IDX_W - 1);
        step_d = bba_pkg::STEP_W'(bba_pkg::IDX_W - 1);
        quo_d  = '0;
      end
    end else if (busy_q) begin
      if (fits) begin
        rem_d = rem_q - dv_q;
      end
      quo_d = {quo_q[bba_pkg::IDX_W-2:0], fits};
      dv_d  = dv_q >> 1;
      if (step_q == '0) begin
        busy_d = 1'b0;
        done_d = 1'b1;
      end else begin
        step_d = step_q - 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
    end else begin
      busy_q <= busy_d;
      done_q <= done_d;
    end
  end

  always_ff @(posedge clk_i) begin
    ovf_q  <= ovf_d;
    step_q <= step_d;
    rem_q  <= rem_d;
    dv_q   <= dv_d;
    quo_q  <= quo_d;
  end

  assign rsp_o.done     = done_q;
  assign rsp_o.overflow = ovf_q;
  assign rsp_o.quotient = quo_q;

endmodule

[design/bitmap_block_allocator.sv]
// Channel  Direction  Handshake                Word
// cfg      in         cfg_valid_i/cfg_ready_o  cfg_index_i, cfg_data_i
// in       in         in_valid_i/in_stall_o    mode_i, request_bytes_i, buffer_address_i
// out      out        out_valid_o/out_stall_i  status_o, block_address_o
//
// An allocate stalls the input through S_FETCH, S_SCAN, S_MUL, S_ADD and S_DONE; its next-fit
// scan reads the map words one per cycle, at most (effective block count + 31) / 32 + 1 of
// them. A free runs the 11-step serial divider, then S_FRD and S_FWR, or goes to S_DONE when
// the quotient overflows; words rejected at once go straight to S_DONE. After reset the map
// is cleared one word per cycle with in_stall_o high. A new word is taken while the previous
// result waits on out_stall_i.
module bitmap_block_allocator #(
  parameter int unsigned ADDRESS_BITS = 48
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          cfg_valid_i,
  output logic                          cfg_ready_o,
  input  logic [bba_pkg::CFG_W-1:0]     cfg_index_i,
  input  logic [bba_pkg::ADDR_W-1:0]    cfg_data_i,
  input  logic                          in_valid_i,
  output logic                          in_stall_o,
  input  logic                          mode_i,
  input  logic [bba_pkg::REQ_W-1:0]     request_bytes_i,
  input  logic [bba_pkg::ADDR_W-1:0]    buffer_address_i,
  output logic                          out_valid_o,
  input  logic                          out_stall_i,
  output logic [1:0]                    status_o,
  output logic [bba_pkg::ADDR_W-1:0]    block_address_o
);

  localparam int unsigned MAP_WORDS = (bba_pkg::MAX_BLOCKS + 31) / 32;
  localparam int unsigned WA_W      = (MAP_WORDS > 1) ? $clog2(MAP_WORDS) : 1;
  localparam logic [16:0] MAX_B     = 17'(bba_pkg::MAX_BLOCKS);
  localparam logic [bba_pkg::ADDR_W-1:0] ADDR_MASK = (ADDRESS_BITS >= 48) ?
      {bba_pkg::ADDR_W{1'b1}} : bba_pkg::ADDR_W'((64'd1 << ADDRESS_BITS) - 64'd1);

  typedef enum logic [9:0] {
    S_CLEAR = 10'b00_0000_0001,
    S_IDLE  = 10'b00_0000_0010,
    S_FETCH = 10'b00_0000_0100,
    S_SCAN  = 10'b00_0000_1000,
    S_MUL   = 10'b00_0001_0000,
    S_ADD   = 10'b00_0010_0000,
    S_DIV   = 10'b00_0100_0000,
    S_FRD   = 10'b00_1000_0000,
    S_FWR   = 10'b01_0000_0000,
    S_DONE  = 10'b10_0000_0000
  } state_e;

  state_e                          state_q, state_d;
  logic [WA_W-1:0]                 clr_q, clr_d;
  logic [bba_pkg::IDX_W-1:0]       pos_q, pos_d;
  logic [bba_pkg::ADDR_W-1:0]      cfg_base_q, cfg_base_d;
  logic [bba_pkg::REQ_W-1:0]       cfg_bytes_q, cfg_bytes_d;
  logic [bba_pkg::CNT_W-1:0]       cfg_count_q, cfg_count_d;
  logic                            out_valid_q, out_valid_d;

  logic [bba_pkg::WI_W-1:0]        word_q, word_d;
  logic [bba_pkg::WI_W-1:0]        sword_q, sword_d;
  logic [bba_pkg::BIT_W-1:0]       sbit_q, sbit_d;
  logic                            first_q, first_d;
  logic [bba_pkg::IDX_W-1:0]       hit_q, hit_d;
  logic [bba_pkg::IDX_W-1:0]       idx_q, idx_d;
  logic [bba_pkg::REM_W-1:0]       prod_q, prod_d;
  bba_pkg::status_e                res_status_q, res_status_d;
  logic [bba_pkg::ADDR_W-1:0]      res_addr_q, res_addr_d;
  bba_pkg::status_e                out_status_q, out_status_d;
  logic [bba_pkg::ADDR_W-1:0]      out_addr_q, out_addr_d;

  logic [bba_pkg::WORD_W-1:0]      map_mem [MAP_WORDS];
  logic [bba_pkg::WORD_W-1:0]      rdata_q;
  logic                            mem_we;
  logic [WA_W-1:0]                 mem_waddr;
  logic [WA_W-1:0]                 mem_raddr;
  logic [bba_pkg::WORD_W-1:0]      mem_wdata;

  logic [bba_pkg::IDX_W-1:0]       n_eff;
  logic [bba_pkg::IDX_W-1:0]       start_pos;
  logic [bba_pkg::WI_W-1:0]        last_word;
  logic [bba_pkg::WI_W-1:0]        next_word;
  logic [bba_pkg::WORD_W-1:0]      lim_mask;
  logic [bba_pkg::WORD_W-1:0]      lo_mask;
  logic [bba_pkg::WORD_W-1:0]      vis_mask;
  logic [bba_pkg::WORD_W-1:0]      cand;
  logic                            found;
  logic [bba_pkg::BIT_W-1:0]       hit_bit;
  logic [bba_pkg::IDX_W-1:0]       hit_idx;
  logic                            in_acc;
  logic                            out_free;
  bba_pkg::div_req_t               div_req;
  bba_pkg::div_rsp_t               div_rsp;

  bba_div u_div (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .req_i  (div_req),
    .rsp_o  (div_rsp)
  );

  assign cfg_ready_o     = 1'b1;
  assign in_stall_o      = (state_q != S_IDLE);
  assign in_acc          = in_valid_i && !in_stall_o;
  assign out_valid_o     = out_valid_q;
  assign status_o        = out_status_q;
  assign block_address_o = out_addr_q;
  assign out_free        = !out_valid_q || !out_stall_i;

  // A count above the map capacity behaves as the capacity.
  assign n_eff = ({6'b0, cfg_count_q} > MAX_B) ? MAX_B[bba_pkg::IDX_W-1:0] : cfg_count_q;
  assign start_pos = (pos_q < n_eff) ? pos_q : '0;
  assign last_word = bba_pkg::WI_W'((n_eff - 1'b1) >> bba_pkg::BIT_W);
  assign next_word = (word_q == last_word) ? '0 : word_q + 1'b1;

  // The start word may be visited twice: first for the bits at and above the start
  // position, and once more at the end of the wrap for the bits below it.
  always_comb begin
    lim_mask = {bba_pkg::WORD_W{1'b1}};
    if (word_q == last_word && n_eff[bba_pkg::BIT_W-1:0] != '0) begin
      lim_mask = (32'd1 << n_eff[bba_pkg::BIT_W-1:0]) - 32'd1;
    end
    lo_mask  = (32'd1 << sbit_q) - 32'd1;
    vis_mask = lim_mask;
    if (word_q == sword_q) begin
      vis_mask = lim_mask & (first_q ? ~lo_mask : lo_mask);
    end
  end

  assign cand  = ~rdata_q & vis_mask;
  assign found = |cand;

  always_comb begin
    hit_bit = '0;
    for (int b = bba_pkg::WORD_W - 1; b >= 0; b--) begin
      if (cand[b]) begin
        hit_bit = bba_pkg::BIT_W'(b);
      end
    end
  end

  assign hit_idx = {word_q, hit_bit};

  always_comb begin
    div_req.start    = 1'b0;
    div_req.dividend = buffer_address_i - cfg_base_q;
    div_req.divisor  = cfg_bytes_q;

    mem_we    = 1'b0;
    mem_waddr = WA_W'(word_q);
    mem_wdata = rdata_q | (32'd1 << hit_bit);
    mem_raddr = WA_W'(word_q);

    state_d      = state_q;
    clr_d        = clr_q;
    pos_d        = pos_q;
    cfg_base_d   = cfg_base_q;
    cfg_bytes_d  = cfg_bytes_q;
    cfg_count_d  = cfg_count_q;
    out_valid_d  = out_valid_q;
    word_d       = word_q;
    sword_d      = sword_q;
    sbit_d       = sbit_q;
    first_d      = first_q;
    hit_d        = hit_q;
    idx_d        = idx_q;
    prod_d       = prod_q;
    res_status_d = res_status_q;
    res_addr_d   = res_addr_q;
    out_status_d = out_status_q;
    out_addr_d   = out_addr_q;

    if (cfg_valid_i && cfg_ready_o) begin
      case (cfg_index_i)
        bba_pkg::CFG_BASE:  cfg_base_d  = cfg_data_i;
        bba_pkg::CFG_BYTES: cfg_bytes_d = cfg_data_i[bba_pkg::REQ_W-1:0];
        bba_pkg::CFG_COUNT: cfg_count_d = cfg_data_i[bba_pkg::CNT_W-1:0];
        default: ;
      endcase
    end

    if (out_valid_q && !out_stall_i) begin
      out_valid_d = 1'b0;
    end

    case (state_q)
      S_CLEAR: begin
        mem_we    = 1'b1;
        mem_waddr = clr_q;
        mem_wdata = '0;
        clr_d     = clr_q + 1'b1;
        if (clr_q == WA_W'(MAP_WORDS - 1)) begin
          state_d = S_IDLE;
        end
      end
      S_IDLE: begin
        if (in_acc) begin
          res_addr_d = '0;
          if (mode_i == bba_pkg::MODE_ALLOC) begin
            if (request_bytes_i > cfg_bytes_q) begin
              res_status_d = bba_pkg::ST_OVERSIZE;
              state_d      = S_DONE;
            end else if (n_eff == '0) begin
              res_status_d = bba_pkg::ST_FULL;
              state_d      = S_DONE;
            end else begin
              word_d  = start_pos[bba_pkg::IDX_W-1:bba_pkg::BIT_W];
              sword_d = start_pos[bba_pkg::IDX_W-1:bba_pkg::BIT_W];
              sbit_d  = start_pos[bba_pkg::BIT_W-1:0];
              first_d = 1'b1;
              state_d = S_FETCH;
            end
          end else begin
            if (cfg_bytes_q == '0 || buffer_address_i < cfg_base_q) begin
              res_status_d = bba_pkg::ST_BADADDR;
              state_d      = S_DONE;
            end else begin
              div_req.start = 1'b1;
              state_d       = S_DIV;
            end
          end
        end
      end
      S_FETCH: begin
        state_d = S_SCAN;
      end
      S_SCAN: begin
        mem_raddr = WA_W'(next_word);
        if (found) begin
          mem_we  = 1'b1;
          pos_d   = hit_idx + 1'b1;
          hit_d   = hit_idx;
          state_d = S_MUL;
        end else if (!first_q && word_q == sword_q) begin
          res_status_d = bba_pkg::ST_FULL;
          state_d      = S_DONE;
        end else begin
          word_d  = next_word;
          first_d = 1'b0;
        end
      end
      S_MUL: begin
        prod_d  = bba_pkg::REM_W'(hit_q) * bba_pkg::REM_W'(cfg_bytes_q);
        state_d = S_ADD;
      end
      S_ADD: begin
        res_addr_d   = (cfg_base_q + bba_pkg::ADDR_W'(prod_q)) & ADDR_MASK;
        res_status_d = bba_pkg::ST_OK;
        state_d      = S_DONE;
      end
      S_DIV: begin
        if (div_rsp.done) begin
          if (div_rsp.overflow || div_rsp.quotient >= n_eff) begin
            res_status_d = bba_pkg::ST_BADADDR;
            state_d      = S_DONE;
          end else begin
            idx_d   = div_rsp.quotient;
            state_d = S_FRD;
          end
        end
      end
      S_FRD: begin
        mem_raddr = WA_W'(idx_q[bba_pkg::IDX_W-1:bba_pkg::BIT_W]);
        state_d   = S_FWR;
      end
      S_FWR: begin
        mem_we       = 1'b1;
        mem_waddr    = WA_W'(idx_q[bba_pkg::IDX_W-1:bba_pkg::BIT_W]);
        mem_wdata    = rdata_q & ~(32'd1 << idx_q[bba_pkg::BIT_W-1:0]);
        res_status_d = bba_pkg::ST_OK;
        state_d      = S_DONE;
      end
      S_DONE: begin
        if (out_free) begin
          out_valid_d  = 1'b1;
          out_status_d = res_status_q;
          out_addr_d   = res_addr_q;
          state_d      = S_IDLE;
        end
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_CLEAR;
      clr_q       <= '0;
      pos_q       <= '0;
      cfg_base_q  <= bba_pkg::RST_BASE;
      cfg_bytes_q <= bba_pkg::RST_BYTES;
      cfg_count_q <= bba_pkg::RST_COUNT;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      clr_q       <= clr_d;
      pos_q       <= pos_d;
      cfg_base_q  <= cfg_base_d;
      cfg_bytes_q <= cfg_bytes_d;
      cfg_count_q <= cfg_count_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    word_q       <= word_d;
    sword_q      <= sword_d;
    sbit_q       <= sbit_d;
    first_q      <= first_d;
    hit_q        <= hit_d;
    idx_q        <= idx_d;
    prod_q       <= prod_d;
    res_status_q <= res_status_d;
    res_addr_q   <= res_addr_d;
    out_status_q <= out_status_d;
    out_addr_q   <= out_addr_d;
  end

  always_ff @(posedge clk_i) begin
    if (mem_we) begin
      map_mem[mem_waddr] <= mem_wdata;
    end
    rdata_q <= map_mem[mem_raddr];
  end

`ifndef SYNTH
  a_addr_zero_on_fail: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && status_o != bba_pkg::ST_OK |-> block_address_o == '0)
    else $error("nonzero block address on a failed request");

  a_hit_in_pool: assert property (@(posedge clk_i) disable iff (!rst_ni)
    state_q == S_SCAN && found |-> hit_idx < n_eff)
    else $error("scan picked a block beyond the pool");

  a_out_from_done: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(out_valid_o) |-> $past(state_q == S_DONE))
    else $error("result word loaded outside the done state");

  a_div_done_in_div: assert property (@(posedge clk_i) disable iff (!rst_ni)
    div_rsp.done |-> state_q == S_DIV)
    else $error("divider finished while no free request was pending");
`endif

endmodule

[tb/testbench.sv]
module testbench;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int unsigned POOL_MAX   = bba_pkg::MAX_BLOCKS;
  localparam logic        MODE_FREE  = ~bba_pkg::MODE_ALLOC;
  localparam int unsigned HOLD_AT    = 200;
  localparam int unsigned HOLD_LEN   = 400;
  localparam int unsigned DRAIN_WAIT = 60;
  localparam int unsigned TIMEOUT_NS = 6_000_000;

  typedef struct packed {
    logic                       mode;
    logic [bba_pkg::REQ_W-1:0]  req;
    logic [bba_pkg::ADDR_W-1:0] addr;
  } request_t;

  typedef struct packed {
    bba_pkg::status_e           status;
    logic [bba_pkg::ADDR_W-1:0] addr;
  } outcome_t;

  logic                       clk_i = 1'b0;
  logic                       rst_ni = 1'b0;
  logic                       cfg_valid_i = 1'b0;
  logic                       cfg_ready_o;
  logic [bba_pkg::CFG_W-1:0]  cfg_index_i = bba_pkg::CFG_BASE;
  logic [bba_pkg::ADDR_W-1:0] cfg_data_i = '0;
  logic                       in_valid_i = 1'b0;
  logic                       in_stall_o;
  logic                       mode_i = bba_pkg::MODE_ALLOC;
  logic [bba_pkg::REQ_W-1:0]  request_bytes_i = '0;
  logic [bba_pkg::ADDR_W-1:0] buffer_address_i = '0;
  logic                       out_valid_o;
  logic                       out_stall_i = 1'b0;
  logic [1:0]                 status_o;
  logic [bba_pkg::ADDR_W-1:0] block_address_o;

  bitmap_block_allocator dut (
    .clk_i            (clk_i),
    .rst_ni           (rst_ni),
    .cfg_valid_i      (cfg_valid_i),
    .cfg_ready_o      (cfg_ready_o),
    .cfg_index_i      (cfg_index_i),
    .cfg_data_i       (cfg_data_i),
    .in_valid_i       (in_valid_i),
    .in_stall_o       (in_stall_o),
    .mode_i           (mode_i),
    .request_bytes_i  (request_bytes_i),
    .buffer_address_i (buffer_address_i),
    .out_valid_o      (out_valid_o),
    .out_stall_i      (out_stall_i),
    .status_o         (status_o),
    .block_address_o  (block_address_o)
  );

  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  // Shadow of the allocator: pool registers, used-block map and search position.
  logic [bba_pkg::ADDR_W-1:0] pool_base  = bba_pkg::RST_BASE;
  logic [bba_pkg::REQ_W-1:0]  pool_bytes = bba_pkg::RST_BYTES;
  logic [bba_pkg::CNT_W-1:0]  pool_count = bba_pkg::RST_COUNT;
  bit                         busy_map [POOL_MAX];
  int unsigned                next_slot = 0;

  request_t    request_q [$];
  outcome_t    outcome_q [$];
  int unsigned mismatch_count = 0;
  int unsigned requests_sent = 0;
  int unsigned blocks_granted = 0;
  int unsigned pool_full_seen = 0;
  int unsigned rejects_seen = 0;
  int unsigned settings_used = 1;
  int unsigned send_wait = 0;
  int unsigned recv_wait = 0;
  int unsigned delivered = 0;

  function automatic int unsigned usable_blocks();
    return (pool_count > POOL_MAX) ? POOL_MAX : int'(pool_count);
  endfunction

  // Applies one request to the shadow state and returns the result it must produce.
  function automatic outcome_t serve_request(request_t rq);
    outcome_t    res;
    int unsigned n;
    int unsigned start;
    int unsigned hit;
    int unsigned i;
    bit          found;
    logic [63:0] quot;
    res.status = bba_pkg::ST_OK;
    res.addr   = '0;
    n = usable_blocks();
    if (rq.mode == bba_pkg::MODE_ALLOC) begin
      if (rq.req > pool_bytes) begin
        res.status = bba_pkg::ST_OVERSIZE;
      end else begin
        start = (next_slot < n) ? next_slot : 0;
        found = 1'b0;
        hit   = 0;
        // Next-fit: walk forward from the position and wrap once around the pool.
        for (i = 0; i < n && !found; i++) begin
          hit = (start + i) % n;
          if (!busy_map[hit]) found = 1'b1;
        end
        if (found) begin
          busy_map[hit] = 1'b1;
          next_slot = hit + 1;
          res.addr = bba_pkg::ADDR_W'(64'(pool_base) + 64'(hit) * 64'(pool_bytes));
        end else begin
          res.status = bba_pkg::ST_FULL;
        end
      end
    end else begin
      if (pool_bytes == '0 || rq.addr < pool_base) begin
        res.status = bba_pkg::ST_BADADDR;
      end else begin
        quot = (64'(rq.addr) - 64'(pool_base)) / 64'(pool_bytes);
        if (quot >= 64'(n)) res.status = bba_pkg::ST_BADADDR;
        else busy_map[quot[bba_pkg::IDX_W-1:0]] = 1'b0;
      end
    end
    return res;
  endfunction

  // Random waits, with stretches of back-to-back traffic in between.
  function automatic int unsigned draw_wait(int unsigned seq);
    if ((seq / 50) % 4 == 0) return 0;
    return $urandom_range(0, 4);
  endfunction

  function automatic void push_alloc(logic [bba_pkg::REQ_W-1:0] size);
    request_t rq;
    rq.mode = bba_pkg::MODE_ALLOC;
    rq.req  = size;
    rq.addr = bba_pkg::ADDR_W'({$urandom(), $urandom()});
    request_q.push_back(rq);
  endfunction

  function automatic void push_free(logic [bba_pkg::ADDR_W-1:0] where);
    request_t rq;
    rq.mode = MODE_FREE;
    rq.req  = bba_pkg::REQ_W'($urandom());
    rq.addr = where;
    request_q.push_back(rq);
  endfunction

  // Mostly well-formed traffic for the current pool: fitting allocations and
  // frees that land inside the pool, with some noise and edge addresses mixed in.
  function automatic void push_random(int unsigned count);
    int unsigned                k;
    int unsigned                pick;
    int unsigned                n;
    int unsigned                idx;
    int unsigned                off;
    logic [bba_pkg::ADDR_W-1:0] where;
    n = usable_blocks();
    for (k = 0; k < count; k++) begin
      pick = $urandom_range(0, 99);
      if (pick < 45) begin
        push_alloc(bba_pkg::REQ_W'($urandom_range(0, pool_bytes)));
      end else if (pick < 50) begin
        push_alloc(bba_pkg::REQ_W'($urandom()));
      end else if (pick < 88) begin
        idx = (n == 0) ? 0 : $urandom_range(0, n - 1);
        off = (pool_bytes == '0) ? 0 : $urandom_range(0, pool_bytes - 1);
        push_free(bba_pkg::ADDR_W'(64'(pool_base) + 64'(idx) * 64'(pool_bytes)
                                   + 64'(off)));
      end else if (pick < 94) begin
        push_free(bba_pkg::ADDR_W'({$urandom(), $urandom()}));
      end else begin
        if ($urandom_range(0, 1) == 0)
          where = pool_base - bba_pkg::ADDR_W'($urandom_range(1, 4));
        else
          where = bba_pkg::ADDR_W'(64'(pool_base) + 64'(n) * 64'(pool_bytes)
                                   + 64'($urandom_range(0, 3)));
        push_free(where);
      end
    end
  endfunction

  task automatic write_reg(logic [bba_pkg::CFG_W-1:0] idx,
                           logic [bba_pkg::ADDR_W-1:0] value);
    @(posedge clk_i);
    cfg_valid_i <= 1'b1;
    cfg_index_i <= idx;
    cfg_data_i  <= value;
    do @(posedge clk_i); while (!cfg_ready_o);
    cfg_valid_i <= 1'b0;
    case (idx)
      bba_pkg::CFG_BASE:  pool_base  = value;
      bba_pkg::CFG_BYTES: pool_bytes = value[bba_pkg::REQ_W-1:0];
      bba_pkg::CFG_COUNT: pool_count = value[bba_pkg::CNT_W-1:0];
      default: ;
    endcase
  endtask

  task automatic program_pool(logic [bba_pkg::ADDR_W-1:0] base,
                              logic [bba_pkg::REQ_W-1:0] bytes,
                              logic [bba_pkg::CNT_W-1:0] count);
    write_reg(bba_pkg::CFG_BASE, base);
    write_reg(bba_pkg::CFG_BYTES, bba_pkg::ADDR_W'(bytes));
    write_reg(bba_pkg::CFG_COUNT, bba_pkg::ADDR_W'(count));
    settings_used++;
  endtask

  // Waits until every queued request went in and every result came back.
  task automatic drain();
    while (request_q.size() != 0 || in_valid_i || outcome_q.size() != 0)
      @(posedge clk_i);
    repeat (4) @(posedge clk_i);
  endtask

  // Request driver.
  always @(posedge clk_i or negedge rst_ni) begin : drive_requests
    request_t rq;
    outcome_t res;
    if (!rst_ni) begin
      in_valid_i       <= 1'b0;
      mode_i           <= bba_pkg::MODE_ALLOC;
      request_bytes_i  <= '0;
      buffer_address_i <= '0;
      send_wait = 0;
    end else begin
      if (in_valid_i && !in_stall_o) begin
        rq.mode = mode_i;
        rq.req  = request_bytes_i;
        rq.addr = buffer_address_i;
        res = serve_request(rq);
        outcome_q.push_back(res);
        requests_sent++;
        if (rq.mode == bba_pkg::MODE_ALLOC && res.status == bba_pkg::ST_OK) blocks_granted++;
        if (res.status == bba_pkg::ST_FULL) pool_full_seen++;
        if (res.status == bba_pkg::ST_OVERSIZE || res.status == bba_pkg::ST_BADADDR)
          rejects_seen++;
        send_wait = draw_wait(requests_sent);
      end
      if (!in_valid_i || !in_stall_o) begin
        if (send_wait > 0) begin
          send_wait--;
          in_valid_i <= 1'b0;
        end else if (request_q.size() != 0) begin
          rq = request_q.pop_front();
          mode_i           <= rq.mode;
          request_bytes_i  <= rq.req;
          buffer_address_i <= rq.addr;
          in_valid_i       <= 1'b1;
        end else begin
          in_valid_i <= 1'b0;
        end
      end
    end
  end

  // Result receiver and checker. One long hold-off lets the block back up.
  always @(posedge clk_i or negedge rst_ni) begin : check_results
    outcome_t res;
    if (!rst_ni) begin
      out_stall_i <= 1'b0;
      recv_wait = 0;
    end else begin
      if (out_valid_o && !out_stall_i) begin
        if (outcome_q.size() == 0) begin
          $display("%0t: unexpected result status=%0d address=%h", $realtime, status_o,
                   block_address_o);
          mismatch_count++;
        end else begin
          res = outcome_q.pop_front();
          if (status_o !== res.status) begin
            $display("%0t: status mismatch, expected %0d, got %0d", $realtime, res.status,
                     status_o);
            mismatch_count++;
          end
          if (block_address_o !== res.addr) begin
            $display("%0t: block address mismatch, expected %h, got %h", $realtime,
                     res.addr, block_address_o);
            mismatch_count++;
          end
        end
        delivered++;
        recv_wait = (delivered == HOLD_AT) ? HOLD_LEN : draw_wait(delivered + 25);
      end
      if (recv_wait > 0) begin
        recv_wait--;
        out_stall_i <= 1'b1;
      end else begin
        out_stall_i <= 1'b0;
      end
    end
  end

  initial begin
    #TIMEOUT_NS;
    $display("[bitmap_block_allocator] ERROR");
    $finish;
  end

  initial begin
    rst_ni = 1'b0;
    repeat (2) @(posedge clk_i);
    rst_ni <= 1'b1;

    // Default pool: size limits, truncating free, double free, next-fit order.
    push_alloc(20'd0);
    push_alloc(20'd4096);
    push_alloc(20'd4097);
    push_alloc(20'hFFFFF);
    push_alloc(20'd1);
    push_free(48'd8191);
    push_free(48'hFFFF_FFFF_FFFF);
    push_free(48'd4194304);
    push_free(48'd4194303);
    push_free(48'd4096);
    push_alloc(20'd0);
    push_random(175);
    drain();

    // Four huge blocks near the top of the address space: results wrap, the pool
    // fills, and the old search position lies past the new count.
    program_pool(48'hFFFF_FFFF_E000, 20'h90000, 11'd4);
    repeat (5) push_alloc(20'h90000);
    push_free(48'hFFFF_FFFF_DFFF);
    push_free(bba_pkg::ADDR_W'(64'h0000_FFFF_FFFF_E000 + 64'h90000 * 4));
    push_free(48'hFFFF_FFFF_E000 + 48'h90005);
    push_alloc(20'h90001);
    push_alloc(20'h1);
    push_random(100);
    drain();

    // A count above capacity acts as the full pool.
    program_pool(48'h1234_5678_9ABC, 20'd1, 11'd2047);
    push_random(175);
    drain();

    // With a zero block size only empty requests succeed and frees are refused.
    program_pool(bba_pkg::ADDR_W'({$urandom(), $urandom()}), 20'd0, 11'd37);
    push_alloc(20'd0);
    push_alloc(20'd1);
    push_free(pool_base);
    push_random(60);
    drain();

    // An empty pool: everything reports full or out of pool.
    program_pool(48'd0, 20'hFFFFF, 11'd0);
    push_alloc(20'd0);
    push_free(48'd0);
    push_random(50);
    drain();

    program_pool(bba_pkg::ADDR_W'({$urandom(), $urandom()}), 20'd64, 11'd33);
    push_random(200);
    drain();

    program_pool(48'd1, 20'd3, 11'd1);
    push_random(60);
    drain();

    program_pool(48'hFFFF_FFFF_FFFF, 20'd4096, 11'd1024);
    push_random(210);
    drain();

    repeat (DRAIN_WAIT) @(posedge clk_i);
    $display("Sent %0d requests over %0d pool settings: %0d blocks granted,", requests_sent,
             settings_used, blocks_granted);
    $display("%0d pool-full answers, %0d requests refused, %0d mismatches.", pool_full_seen,
             rejects_seen, mismatch_count);
    if (mismatch_count == 0) begin
      $display("[bitmap_block_allocator] OK");
    end else begin
      $display("[bitmap_block_allocator] ERROR");
    end
    $finish;
  end

endmodule
